>>> sv/julia_escape_time_defines.svh
// Assertion macros for the Julia escape-time block.
// Included by julia_escape_time.sv; needs nothing else.
`ifndef JULIA_ESCAPE_TIME_DEFINES_SVH
`define JULIA_ESCAPE_TIME_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JET_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("julia_escape_time: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define JET_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("julia_escape_time: next-cycle check failed");

`endif

>>> sv/jet_pkg.sv
// Shared types and constants for the Julia escape-time block.
// Used by jet_datapath.sv and julia_escape_time.sv; no dependencies.
package jet_pkg;

    localparam int COORD_W    = 32;
    localparam int C_W        = 31;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_C_REAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd2;

    // Register values after reset: 0.2, 0.3 in Q3.28 and a limit of 1000
    localparam logic signed [C_W-1:0] RST_C_REAL   = 31'sd53687091;
    localparam logic signed [C_W-1:0] RST_C_IMAG   = 31'sd80530637;
    localparam logic [CNT_W-1:0]      RST_MAX_ITER = 16'd1000;

    // Operand choice for the shared multiplier
    typedef enum logic [1:0] {
        MUL_SQ_X  = 2'd0,
        MUL_SQ_Y  = 2'd1,
        MUL_CROSS = 2'd2
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     step;
    } t_dp_ctrl;

    typedef struct packed {
        logic escape;
    } t_dp_stat;

endpackage

>>> sv/jet_datapath.sv
// Iterate datapath: holds z, shares one 32x32 signed multiplier across
// the three products of an iteration and forms the next z. Uses jet_pkg.
module jet_datapath #(
    parameter int FRAC_BITS = 28
) (
    input  logic                                 i_clk,
    input  jet_pkg::t_dp_ctrl                    i_ctrl,
    input  logic signed [jet_pkg::COORD_W-1:0]   i_real_part,
    input  logic signed [jet_pkg::COORD_W-1:0]   i_imag_part,
    input  logic signed [jet_pkg::C_W-1:0]       i_c_real,
    input  logic signed [jet_pkg::C_W-1:0]       i_c_imag,
    output jet_pkg::t_dp_stat                    o_stat
);

    localparam int PW = 2 * jet_pkg::COORD_W;
    localparam int SW = PW + 2;
    localparam logic [PW:0] LIMIT = (PW + 1)'(4) << FRAC_BITS;

    logic signed [jet_pkg::COORD_W-1:0] r_x, r_y;
    logic signed [jet_pkg::COORD_W-1:0] n_x, n_y;
    logic [PW-1:0]                      r_x2, r_y2;
    logic signed [PW-1:0]               r_xy;

    logic signed [jet_pkg::COORD_W-1:0] mul_a, mul_b;
    logic signed [PW-1:0]               mul_p;
    logic signed [PW:0]                 xy2, xy_sh;
    logic signed [SW-1:0]               c_re_ext, c_im_ext, nx, ny;

    function automatic logic signed [jet_pkg::COORD_W-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi, lo;
        hi = SW'($signed({1'b0, {(jet_pkg::COORD_W-1){1'b1}}}));
        lo = -hi - SW'(1);
        if (v > hi) begin
            return hi[jet_pkg::COORD_W-1:0];
        end else if (v < lo) begin
            return lo[jet_pkg::COORD_W-1:0];
        end
        return v[jet_pkg::COORD_W-1:0];
    endfunction

    // Multiplier operands
    always_comb begin
        case (i_ctrl.mul_sel)
            jet_pkg::MUL_SQ_X: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            jet_pkg::MUL_SQ_Y: begin
                mul_a = r_y;
                mul_b = r_y;
            end
            default: begin
                mul_a = r_x;
                mul_b = r_y;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Squares are never negative, so their sum is compared unsigned against 4.0
    assign o_stat.escape = ({1'b0, r_x2} + {1'b0, r_y2}) >= LIMIT;

    assign c_re_ext = {{(SW-jet_pkg::C_W){i_c_real[jet_pkg::C_W-1]}}, i_c_real};
    assign c_im_ext = {{(SW-jet_pkg::C_W){i_c_imag[jet_pkg::C_W-1]}}, i_c_imag};

    // Exact signed product doubled, then floored back to the fixed-point grid
    assign xy2   = {r_xy, 1'b0};
    assign xy_sh = xy2 >>> FRAC_BITS;

    assign nx = $signed({2'b00, r_x2}) - $signed({2'b00, r_y2}) + c_re_ext;
    assign ny = {xy_sh[PW], xy_sh} + c_im_ext;

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        if (i_ctrl.load) begin
            n_x = i_real_part;
            n_y = i_imag_part;
        end else if (i_ctrl.step) begin
            n_x = sat(nx);
            n_y = sat(ny);
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        if (i_ctrl.mul_en) begin
            case (i_ctrl.mul_sel)
                jet_pkg::MUL_SQ_X: r_x2 <= PW'(mul_p >>> FRAC_BITS);
                jet_pkg::MUL_SQ_Y: r_y2 <= PW'(mul_p >>> FRAC_BITS);
                default:           r_xy <= mul_p;
            endcase
        end
    end

endmodule

>>> sv/julia_escape_time.sv
// Julia escape-time counter: top level with sequencer, configuration
// registers and result register. Uses jet_pkg, jet_datapath and the defines header.
//
//  channel   direction  handshake             payload
//  input     in         i_valid / o_ready     i_real_part, i_imag_part
//  result    out        o_valid / i_ready     o_iteration_count
//  config    in         i_cfg_we              i_cfg_index, i_cfg_data
//
// Each iteration runs ST_MUL_X (x*x), ST_MUL_Y (y*y), ST_MUL_XY (x*y)
// and ST_STEP (the update) on the one shared multiplier. A result is
// loaded in ST_FINISH, entered when the count reaches the limit or z escapes;
// o_ready is low while an item is iterated and rises with the result.
// A finished result waits in the output register; the sequencer holds only
// while it is full and unread. Reset restores c = 0.2 + 0.3i, limit 1000.
`include "julia_escape_time_defines.svh"

module julia_escape_time #(
    parameter int FRAC_BITS = 28
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [jet_pkg::COORD_W-1:0]     i_real_part,
    input  logic signed [jet_pkg::COORD_W-1:0]     i_imag_part,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [jet_pkg::CNT_W-1:0]              o_iteration_count,
    input  logic                                   i_cfg_we,
    input  logic [jet_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [jet_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MUL_X  = 6'b000010,
        ST_MUL_Y  = 6'b000100,
        ST_MUL_XY = 6'b001000,
        ST_STEP   = 6'b010000,
        ST_FINISH = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic signed [jet_pkg::C_W-1:0] r_c_real, r_c_imag;
    logic [jet_pkg::CNT_W-1:0]      r_max;
    logic [jet_pkg::CNT_W-1:0]      r_count, n_count;
    logic [jet_pkg::CNT_W-1:0]      r_out;
    logic                           r_out_valid;

    jet_pkg::t_dp_ctrl dp_ctrl;
    jet_pkg::t_dp_stat dp_stat;

    logic in_acc, out_acc, out_load;

    assign o_ready           = (r_state == ST_IDLE);
    assign in_acc            = i_valid && o_ready;
    assign out_acc           = r_out_valid && i_ready;
    assign out_load          = (r_state == ST_FINISH) && (!r_out_valid || i_ready);
    assign o_valid           = r_out_valid;
    assign o_iteration_count = r_out;

    // Sequencer
    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        dp_ctrl.load    = 1'b0;
        dp_ctrl.mul_en  = 1'b0;
        dp_ctrl.mul_sel = jet_pkg::MUL_SQ_X;
        dp_ctrl.step    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    dp_ctrl.load = 1'b1;
                    n_count      = '0;
                    n_state      = ST_MUL_X;
                end
            end
            ST_MUL_X: begin
                if (r_count >= r_max) begin
                    n_state = ST_FINISH;
                end else begin
                    dp_ctrl.mul_en = 1'b1;
                    n_state        = ST_MUL_Y;
                end
            end
            ST_MUL_Y: begin
                dp_ctrl.mul_en  = 1'b1;
                dp_ctrl.mul_sel = jet_pkg::MUL_SQ_Y;
                n_state         = ST_MUL_XY;
            end
            ST_MUL_XY: begin
                dp_ctrl.mul_sel = jet_pkg::MUL_CROSS;
                if (dp_stat.escape) begin
                    n_state = ST_FINISH;
                end else begin
                    dp_ctrl.mul_en = 1'b1;
                    n_state        = ST_STEP;
                end
            end
            ST_STEP: begin
                dp_ctrl.step = 1'b1;
                n_count      = r_count + 1'b1;
                n_state      = ST_MUL_X;
            end
            ST_FINISH: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_c_real    <= jet_pkg::RST_C_REAL;
            r_c_imag    <= jet_pkg::RST_C_IMAG;
            r_max       <= jet_pkg::RST_MAX_ITER;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    jet_pkg::CFG_C_REAL:   r_c_real <= $signed(i_cfg_data);
                    jet_pkg::CFG_C_IMAG:   r_c_imag <= $signed(i_cfg_data);
                    jet_pkg::CFG_MAX_ITER: r_max    <= i_cfg_data[jet_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_count;
        end
    end

    jet_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_ctrl      (dp_ctrl),
        .i_real_part (i_real_part),
        .i_imag_part (i_imag_part),
        .i_c_real    (r_c_real),
        .i_c_imag    (r_c_imag),
        .o_stat      (dp_stat)
    );

    `JET_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, r_state != ST_IDLE, r_count <= r_max)
    `JET_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_acc, r_state == ST_MUL_X && r_count == '0)
    `JET_ASSERT_IMP(a_result_source, i_clk, i_rst_n, $rose(o_valid), $past(r_state == ST_FINISH))

endmodule
